// ===== rtl/core/ebbl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbl_pkg: shared types and constants of the box blur line unit
// Sizes of the pixel ring, the sums and the front-to-back queue, and the
// command word that the front hands to the back.
// ----------------------------------------------------------------------------
package ebbl_pkg;

    localparam int MAX_RADIUS = 31;
    localparam int MAX_LINE   = 4096;
    localparam int RING_DEPTH = 2 * MAX_RADIUS + 2;
    localparam int RING_AW    = $clog2(RING_DEPTH);
    localparam int POS_W      = $clog2(MAX_LINE);
    localparam int LEN_W      = 13;
    localparam int RAD_W      = 5;
    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = NUM_CH * CH_W;
    localparam int WORD_W     = 32;
    localparam int SUM_W      = 14;
    localparam int CNT_W      = $clog2(RING_DEPTH);
    localparam int RECIP_SH   = 20;
    localparam int RECIP_W    = RECIP_SH + 1;
    localparam int PROD_W     = SUM_W + RECIP_W;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);

    localparam logic [CH_W-1:0] ALPHA_OPAQUE = 8'hff;
    localparam logic [CH_W-1:0] CH_MAX       = 8'hff;

    // configuration register indexes
    localparam logic CFG_RADIUS      = 1'b0;
    localparam logic CFG_LINE_LENGTH = 1'b1;

    // one command for the back: drop a pixel, add a pixel, emit a result
    typedef struct packed {
        logic             clr;
        logic             rm;
        logic             add;
        logic             emit;
        logic             line_end;
        logic             last;
        logic [PIX_W-1:0] rm_px;
        logic [PIX_W-1:0] add_px;
    } ebbl_op_t;

    typedef struct packed {
        logic              empty;
        logic [QCNT_W-1:0] count;
    } ebbl_qstat_t;

endpackage

// ===== rtl/core/edge_normalized_box_blur_line_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// edge_normalized_box_blur_line_unit: box blur along one image line
// Running-sum box filter with edge-normalized averaging and end-of-line flush.
// ----------------------------------------------------------------------------
// Usage:
//   Feed one ARGB word per pixel on s_* in line order. Each result word on
//   m_* carries the averaged pixel (alpha 0xff), m_tlast on the last word
//   caused by an input word and m_tuser on the last pixel of the line.
//   Set radius and line_length on the cfg_* port while the unit is idle;
//   both are latched on the first pixel of each line.
// Throughput and flush:
//   One input word per cycle while the command queue has room and no
//   flush runs. The first result of a line appears once radius+1 pixels
//   are in. After the last pixel of a line s_tready stays low while the
//   front reads the ring to flush the tail, one command per tail pixel.
//   The pace is set by the single read port of the 64-entry pixel ring.
// Reset and stall:
//   Reset restores radius 1 and line length 640 and starts a new line; the
//   ring needs no clearing. When m_tready is low with a word on m_*, the
//   output register and the back pipeline hold; the 4-deep command queue
//   then fills and the front drops s_tready until room is made.
// ----------------------------------------------------------------------------
module edge_normalized_box_blur_line_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write port
    input  logic                            cfg_wr_en,
    input  logic                            cfg_index,
    input  logic [ebbl_pkg::LEN_W-1:0]      cfg_data,
    // input pixels
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [ebbl_pkg::WORD_W-1:0]     s_tdata,   // [31:0] pixel_in
    // output pixels
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [ebbl_pkg::WORD_W-1:0]     m_tdata,   // [31:0] pixel_out
    output logic                            m_tlast,   // last_of_run
    output logic                            m_tuser    // [0] line_end
);

    logic [ebbl_pkg::RAD_W-1:0] radius_reg;
    logic [ebbl_pkg::LEN_W-1:0] line_length_reg;

    ebbl_pkg::ebbl_qstat_t qstat;
    ebbl_pkg::ebbl_op_t    push_op;
    ebbl_pkg::ebbl_op_t    head_op;
    logic                  push;
    logic                  pop;

    // register file: radius resets to 1, line length to 640
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg      <= ebbl_pkg::RAD_W'(1);
            line_length_reg <= ebbl_pkg::LEN_W'(640);
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                ebbl_pkg::CFG_RADIUS:
                begin
                    radius_reg <= cfg_data[ebbl_pkg::RAD_W-1:0];
                end
                ebbl_pkg::CFG_LINE_LENGTH:
                begin
                    line_length_reg <= cfg_data;
                end
                default:
                begin
                    radius_reg <= radius_reg;
                end
            endcase
        end
    end

    // front: accept pixels, keep the ring, issue add/drop/emit commands
    ebbl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .in_px       (s_tdata[ebbl_pkg::PIX_W-1:0]),
        .radius      (radius_reg),
        .line_length (line_length_reg),
        .qstat       (qstat),
        .push        (push),
        .push_op     (push_op)
    );

    // decouple the two halves so either side can stall alone
    ebbl_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .push_op (push_op),
        .pop     (pop),
        .head_op (head_op),
        .stat    (qstat)
    );

    // back: advance the sums, divide, present the word
    ebbl_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_op      (head_op),
        .qstat        (qstat),
        .pop          (pop),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_px       (m_tdata),
        .out_last     (m_tlast),
        .out_line_end (m_tuser)
    );

endmodule

// ===== rtl/core/ebbl_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbl_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module ebbl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem_reg[raddr];
        end
    end

endmodule

// ===== rtl/core/ebbl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbl_queue: short command queue between front and back
// First-word-fall-through FIFO; the front pushes only when it holds credit.
// ----------------------------------------------------------------------------
module ebbl_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  ebbl_pkg::ebbl_op_t    push_op,
    input  logic                  pop,
    output ebbl_pkg::ebbl_op_t    head_op,
    output ebbl_pkg::ebbl_qstat_t stat
);

    ebbl_pkg::ebbl_op_t                  slot_reg [ebbl_pkg::QDEPTH];
    logic [ebbl_pkg::QPTR_W-1:0]         wptr_reg;
    logic [ebbl_pkg::QPTR_W-1:0]         rptr_reg;
    logic [ebbl_pkg::QCNT_W-1:0]         count_reg;
    logic [ebbl_pkg::QCNT_W-1:0]         count_next;

    assign head_op    = slot_reg[rptr_reg];
    assign stat.empty = (count_reg == '0);
    assign stat.count = count_reg;

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wptr_reg] <= push_op;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wptr_reg <= wptr_reg + 1'b1;
            end
            if (pop)
            begin
                rptr_reg <= rptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ===== rtl/core/ebbl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbl_front: input side of the box blur line unit
// Accept pixels, track the line position, keep the pixel ring and issue
// add/drop/emit commands, including the flush at the end of each line.
// ----------------------------------------------------------------------------
module ebbl_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [ebbl_pkg::PIX_W-1:0]     in_px,
    input  logic [ebbl_pkg::RAD_W-1:0]     radius,
    input  logic [ebbl_pkg::LEN_W-1:0]     line_length,
    input  ebbl_pkg::ebbl_qstat_t          qstat,
    output logic                           push,
    output ebbl_pkg::ebbl_op_t             push_op
);

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_FLUSH = 1'b1;

    localparam int POS_W = ebbl_pkg::POS_W;
    localparam int RAD_W = ebbl_pkg::RAD_W;
    localparam int AW    = ebbl_pkg::RING_AW;

    logic                  state_reg, state_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [POS_W-1:0]      lm1_reg, lm1_next;
    logic [RAD_W-1:0]      rad_reg, rad_next;
    logic [POS_W-1:0]      fj_reg, fj_next;
    logic                  pend_reg;
    ebbl_pkg::ebbl_op_t    pend_op_reg, pend_op_next;

    logic [ebbl_pkg::LEN_W-1:0] len_eff;
    logic [POS_W-1:0]      cfg_lm1;
    logic [POS_W-1:0]      r_cap;
    logic [RAD_W-1:0]      r_lim;
    logic [RAD_W-1:0]      cfg_rad;
    logic [POS_W-1:0]      cur_lm1;
    logic [RAD_W-1:0]      cur_rad;
    logic [RAD_W:0]        win;
    logic                  space;
    logic                  accept;
    logic                  fl_issue;
    logic                  item_last;
    logic [AW-1:0]         item_addr;
    logic [AW-1:0]         fl_addr;
    logic                  fl_end;
    logic                  ram_re;
    logic [AW-1:0]         ram_raddr;
    logic [ebbl_pkg::PIX_W-1:0] ram_rdata;

    ebbl_ram #(
        .WIDTH (ebbl_pkg::PIX_W),
        .DEPTH (ebbl_pkg::RING_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (accept),
        .waddr (pos_reg[AW-1:0]),
        .wdata (in_px),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // line geometry from the registers, used on the first pixel of a line
    always_comb
    begin
        if (line_length == '0)
        begin
            len_eff = ebbl_pkg::LEN_W'(1);
        end
        else if (line_length > ebbl_pkg::LEN_W'(ebbl_pkg::MAX_LINE))
        begin
            len_eff = ebbl_pkg::LEN_W'(ebbl_pkg::MAX_LINE);
        end
        else
        begin
            len_eff = line_length;
        end
        cfg_lm1 = POS_W'(len_eff - 1'b1);
        r_cap   = cfg_lm1 >> 1;
        r_lim   = (radius > RAD_W'(ebbl_pkg::MAX_RADIUS)) ?
                  RAD_W'(ebbl_pkg::MAX_RADIUS) : radius;
        cfg_rad = (POS_W'(r_lim) > r_cap) ? RAD_W'(r_cap) : r_lim;
    end

    assign cur_lm1   = (pos_reg == '0) ? cfg_lm1 : lm1_reg;
    assign cur_rad   = (pos_reg == '0) ? cfg_rad : rad_reg;
    assign win       = {cur_rad, 1'b1};
    assign space     = (({1'b0, qstat.count} + (ebbl_pkg::QCNT_W + 1)'(pend_reg))
                        < (ebbl_pkg::QCNT_W + 1)'(ebbl_pkg::QDEPTH));
    assign in_ready  = (state_reg == ST_RUN) && space;
    assign accept    = in_valid && in_ready;
    assign fl_issue  = (state_reg == ST_FLUSH) && space;
    assign item_last = (pos_reg == cur_lm1);
    assign item_addr = pos_reg[AW-1:0] - AW'(win);
    assign fl_addr   = fj_reg[AW-1:0] - AW'(rad_reg) - 1'b1;
    assign fl_end    = (fj_reg == lm1_reg);
    assign ram_re    = accept || fl_issue;
    assign ram_raddr = (state_reg == ST_FLUSH) ? fl_addr : item_addr;

    // removed pixel comes back from the ring in the cycle after the read
    always_comb
    begin
        push_op       = pend_op_reg;
        push_op.rm_px = ram_rdata;
        push          = pend_reg;
    end

    always_comb
    begin
        state_next   = state_reg;
        pos_next     = pos_reg;
        lm1_next     = lm1_reg;
        rad_next     = rad_reg;
        fj_next      = fj_reg;
        pend_op_next = pend_op_reg;
        if (accept)
        begin
            lm1_next              = cur_lm1;
            rad_next              = cur_rad;
            pend_op_next.clr      = (pos_reg == '0);
            pend_op_next.rm       = (pos_reg >= POS_W'(win));
            pend_op_next.add      = 1'b1;
            pend_op_next.emit     = (pos_reg >= POS_W'(cur_rad));
            pend_op_next.line_end = item_last && (cur_rad == '0);
            pend_op_next.last     = !item_last || (cur_rad == '0);
            pend_op_next.rm_px    = '0;
            pend_op_next.add_px   = in_px;
            if (item_last)
            begin
                pos_next = '0;
                if (cur_rad != '0)
                begin
                    state_next = ST_FLUSH;
                    fj_next    = cur_lm1 - POS_W'(cur_rad) + 1'b1;
                end
            end
            else
            begin
                pos_next = pos_reg + 1'b1;
            end
        end
        else if (fl_issue)
        begin
            pend_op_next.clr      = 1'b0;
            pend_op_next.rm       = (fj_reg >= (POS_W'(rad_reg) + 1'b1));
            pend_op_next.add      = 1'b0;
            pend_op_next.emit     = 1'b1;
            pend_op_next.line_end = fl_end;
            pend_op_next.last     = fl_end;
            pend_op_next.rm_px    = '0;
            pend_op_next.add_px   = '0;
            fj_next               = fj_reg + 1'b1;
            if (fl_end)
            begin
                state_next = ST_RUN;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_op_reg <= pend_op_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_RUN;
            pos_reg   <= '0;
            lm1_reg   <= '0;
            rad_reg   <= '0;
            fj_reg    <= '0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            lm1_reg   <= lm1_next;
            rad_reg   <= rad_next;
            fj_reg    <= fj_next;
            pend_reg  <= ram_re;
        end
    end

endmodule

// ===== rtl/core/ebbl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ebbl_back: running sums and averaging pipeline
// Apply queued commands to the channel sums, divide by the window count
// through a reciprocal multiply, and hold the result in the output register.
// ----------------------------------------------------------------------------
module ebbl_back (
    input  logic                            clk,
    input  logic                            rst_n,
    input  ebbl_pkg::ebbl_op_t              head_op,
    input  ebbl_pkg::ebbl_qstat_t           qstat,
    output logic                            pop,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [ebbl_pkg::WORD_W-1:0]     out_px,
    output logic                            out_last,
    output logic                            out_line_end
);

    localparam int SUM_W  = ebbl_pkg::SUM_W;
    localparam int CNT_W  = ebbl_pkg::CNT_W;
    localparam int CH_W   = ebbl_pkg::CH_W;
    localparam int NCH    = ebbl_pkg::NUM_CH;
    localparam int PROD_W = ebbl_pkg::PROD_W;
    localparam int QW     = PROD_W - ebbl_pkg::RECIP_SH;
    localparam int PIX_W_FILL = ebbl_pkg::WORD_W - CH_W;

    logic [ebbl_pkg::RECIP_W-1:0] recip_tbl [ebbl_pkg::RING_DEPTH];

    // ceil(2^RECIP_SH / w): exact floor quotient for every sum below 2^SUM_W
    for (genvar w = 0; w < ebbl_pkg::RING_DEPTH; w++)
    begin : g_recip
        if (w == 0)
        begin : g_zero
            assign recip_tbl[w] = '0;
        end
        else
        begin : g_val
            localparam longint unsigned RC =
                ((64'd1 << ebbl_pkg::RECIP_SH) + w - 1) / w;
            assign recip_tbl[w] = ebbl_pkg::RECIP_W'(RC);
        end
    end

    logic [NCH-1:0][SUM_W-1:0]  sum_reg, sum_next;
    logic [CNT_W-1:0]           cnt_reg, cnt_next;
    logic [NCH-1:0][SUM_W-1:0]  base_sum;
    logic [CNT_W-1:0]           base_cnt;
    logic [CNT_W-1:0]           drop_cnt;

    logic                       adv;
    logic                       e1_valid_reg;
    logic [NCH-1:0][SUM_W-1:0]  e1_sum_reg;
    logic [CNT_W-1:0]           e1_cnt_reg;
    logic                       e1_last_reg, e1_end_reg;
    logic                       e2_valid_reg;
    logic [NCH-1:0][PROD_W-1:0] e2_prod_reg, e2_prod_next;
    logic                       e2_last_reg, e2_end_reg;
    logic                       o_valid_reg;
    logic [ebbl_pkg::WORD_W-1:0] o_px_reg, o_px_next;
    logic                       o_last_reg, o_end_reg;
    logic [QW-1:0]              quo;

    assign adv = !o_valid_reg || out_ready;
    assign pop = !qstat.empty && adv;

    always_comb
    begin
        base_sum = head_op.clr ? '0 : sum_reg;
        base_cnt = head_op.clr ? '0 : cnt_reg;
        drop_cnt = (head_op.rm && (base_cnt != '0)) ? base_cnt - 1'b1 : base_cnt;
        cnt_next = drop_cnt + CNT_W'(head_op.add);
        for (int i = 0; i < NCH; i++)
        begin
            sum_next[i] = base_sum[i]
                - (head_op.rm  ? SUM_W'(head_op.rm_px[i*CH_W +: CH_W])  : '0)
                + (head_op.add ? SUM_W'(head_op.add_px[i*CH_W +: CH_W]) : '0);
        end
    end

    always_comb
    begin
        for (int i = 0; i < NCH; i++)
        begin
            e2_prod_next[i] = PROD_W'(e1_sum_reg[i]) * PROD_W'(recip_tbl[e1_cnt_reg]);
        end
    end

    // drop the fraction, clamp to a byte, force alpha opaque
    always_comb
    begin
        o_px_next = {ebbl_pkg::ALPHA_OPAQUE, {PIX_W_FILL{1'b0}}};
        quo       = '0;
        for (int i = 0; i < NCH; i++)
        begin
            quo = e2_prod_reg[i][PROD_W-1:ebbl_pkg::RECIP_SH];
            o_px_next[i*CH_W +: CH_W] =
                (quo > QW'(ebbl_pkg::CH_MAX)) ? ebbl_pkg::CH_MAX : quo[CH_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            sum_reg <= sum_next;
        end
        if (adv)
        begin
            e1_sum_reg  <= sum_next;
            e1_cnt_reg  <= cnt_next;
            e1_last_reg <= head_op.last;
            e1_end_reg  <= head_op.line_end;
            e2_prod_reg <= e2_prod_next;
            e2_last_reg <= e1_last_reg;
            e2_end_reg  <= e1_end_reg;
            o_px_reg    <= o_px_next;
            o_last_reg  <= e2_last_reg;
            o_end_reg   <= e2_end_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg      <= '0;
            e1_valid_reg <= 1'b0;
            e2_valid_reg <= 1'b0;
            o_valid_reg  <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                cnt_reg <= cnt_next;
            end
            if (adv)
            begin
                e1_valid_reg <= pop && head_op.emit;
                e2_valid_reg <= e1_valid_reg;
                o_valid_reg  <= e2_valid_reg;
            end
        end
    end

    assign out_valid    = o_valid_reg;
    assign out_px       = o_px_reg;
    assign out_last     = o_last_reg;
    assign out_line_end = o_end_reg;

endmodule
